### src/lfu_pkg.sv
// Shared types and constants for the LFU cache directory.
// No dependencies; imported by lfu_ctrl, lfu_datapath and lfu_cache_directory.
package lfu_pkg;

  // Default sizing handed to the top-level parameters
  localparam int unsigned LFU_ENTRIES    = 16;
  localparam int unsigned LFU_KEY_BITS   = 16;
  localparam int unsigned LFU_COUNT_BITS = 16;

  // Fixed field widths on the ports
  localparam int unsigned KEY_W   = 16;
  localparam int unsigned VALUE_W = 32;
  localparam int unsigned CAP_W   = 5;
  localparam int unsigned STAMP_W = 32;

  // Packed stream widths
  localparam int unsigned S_DATA_W = 48;  // key, value
  localparam int unsigned M_DATA_W = 48;  // read_value, evicted_key
  localparam int unsigned M_USER_W = 2;   // found, evicted

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Request operation codes
  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_e;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming request
    logic search;  // register lookup and victim results
    logic commit;  // update entries and load the result register
  } lfu_cmd_t;

endpackage

### src/lfu_ctrl.sv
// Sequencing state machine for the LFU cache directory.
// Depends on lfu_pkg for the command struct.
module lfu_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  output logic            rsp_valid_o,
  input  logic            rsp_ready_i,
  output lfu_pkg::lfu_cmd_t cmd_o
);
  import lfu_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_COMMIT = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   out_free;

  // Result register may be loaded when empty or draining this cycle
  assign out_free    = !rsp_valid_q || rsp_ready_i;
  assign req_ready_o = (state_q == ST_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  always_comb begin
    cmd_o.load   = (state_q == ST_IDLE) && req_valid_i;
    cmd_o.search = (state_q == ST_SEARCH);
    cmd_o.commit = (state_q == ST_COMMIT) && out_free;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (req_valid_i) state_d = ST_SEARCH;
      end
      ST_SEARCH: state_d = ST_COMMIT;
      ST_COMMIT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Result valid flag
  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (cmd_o.commit) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // An accepted request always goes to the search step next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q == ST_SEARCH))
    else $error("accepted request did not start a search");

  // A commit never overwrites a result that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_q && !rsp_ready_i) |=> !$past(cmd_o.commit) || rsp_valid_q)
    else $error("pending result lost");

  // Search is always followed by the commit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) |=> (state_q == ST_COMMIT))
    else $error("search not followed by commit");

endmodule

### src/lfu_datapath.sv
// Entry storage, parallel key compare, victim min tree and result register.
// Depends on lfu_pkg for widths, op codes and the command struct.
module lfu_datapath #(
  parameter int unsigned ENTRIES    = lfu_pkg::LFU_ENTRIES,
  parameter int unsigned KEY_BITS   = lfu_pkg::LFU_KEY_BITS,
  parameter int unsigned COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lfu_pkg::lfu_cmd_t            cmd_i,
  input  logic                         cfg_valid_i,
  input  logic [lfu_pkg::CAP_W-1:0]    cfg_data_i,
  input  logic                         req_op_i,
  input  logic [lfu_pkg::KEY_W-1:0]    req_key_i,
  input  logic [lfu_pkg::VALUE_W-1:0]  req_value_i,
  output logic                         rsp_found_o,
  output logic [lfu_pkg::VALUE_W-1:0]  rsp_read_value_o,
  output logic                         rsp_evicted_o,
  output logic [lfu_pkg::KEY_W-1:0]    rsp_evicted_key_o
);
  import lfu_pkg::*;

  localparam int unsigned IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned OCC_W = $clog2(ENTRIES + 1);
  localparam int unsigned CMP_W = (OCC_W > CAP_W) ? OCC_W : CAP_W;
  localparam int unsigned LVL   = $clog2(ENTRIES);
  localparam int unsigned LEAVES = 1 << LVL;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic                  vld;
    logic [COUNT_BITS-1:0] cnt;
    logic [STAMP_W-1:0]    stamp;
    logic [IDX_W-1:0]      idx;
  } node_t;

  // Entry storage
  logic                  valid_q [ENTRIES];
  logic [KEY_BITS-1:0]   key_q   [ENTRIES];
  logic [VALUE_W-1:0]    val_q   [ENTRIES];
  logic [COUNT_BITS-1:0] cnt_q   [ENTRIES];
  logic [STAMP_W-1:0]    stamp_q [ENTRIES];

  logic [OCC_W-1:0]   occ_q;
  logic [STAMP_W-1:0] clock_q;
  logic [CAP_W-1:0]   cap_q;

  // Request registers
  logic                op_q;
  logic [KEY_BITS-1:0] rkey_q;
  logic [VALUE_W-1:0]  rval_q;

  // Search results
  logic             hit_q, free_vld_q, vic_vld_q, full_q;
  logic [IDX_W-1:0] hit_idx_q, free_idx_q, vic_idx_q;

  // Result register
  logic               found_q, ev_q;
  logic [VALUE_W-1:0] rd_q;
  logic [KEY_W-1:0]   evkey_q;

  logic             hit_c, free_c;
  logic [IDX_W-1:0] hit_idx_c, free_idx_c;
  node_t            nodes [2*LEAVES-1];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_RESET;
    end else if (cfg_valid_i) begin
      cap_q <= cfg_data_i;
    end
  end

  // Capture request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q   <= req_op_i;
      rkey_q <= KEY_BITS'(req_key_i);
      rval_q <= req_value_i;
    end
  end

  // Parallel key compare and free slot search, lowest index first
  always_comb begin
    hit_c      = 1'b0;
    hit_idx_c  = '0;
    free_c     = 1'b0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_q[i] && (key_q[i] == rkey_q)) begin
        hit_c     = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (!valid_q[i]) begin
        free_c     = 1'b1;
        free_idx_c = IDX_W'(i);
      end
    end
  end

  // Victim min tree: lowest (count, stamp), then lowest index
  for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
    if (i < ENTRIES) begin : g_used
      assign nodes[LEAVES-1+i] = '{vld: valid_q[i], cnt: cnt_q[i], stamp: stamp_q[i],
                                   idx: IDX_W'(i)};
    end else begin : g_pad
      assign nodes[LEAVES-1+i] = '{vld: 1'b0, cnt: '0, stamp: '0, idx: '0};
    end
  end
  for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
    node_t lft, rgt;
    assign lft = nodes[2*n+1];
    assign rgt = nodes[2*n+2];
    assign nodes[n] = (rgt.vld && (!lft.vld || (rgt.cnt < lft.cnt) ||
                      ((rgt.cnt == lft.cnt) && (rgt.stamp < lft.stamp)))) ? rgt : lft;
  end

  // Register search results
  always_ff @(posedge clk_i) begin
    if (cmd_i.search) begin
      hit_q      <= hit_c;
      hit_idx_q  <= hit_idx_c;
      free_vld_q <= free_c;
      free_idx_q <= free_idx_c;
      vic_vld_q  <= nodes[0].vld;
      vic_idx_q  <= nodes[0].idx;
      full_q     <= (CMP_W'(occ_q) >= CMP_W'(cap_q));
    end
  end

  // Commit decode
  logic                  active, is_get, do_upd, do_ins, do_ev, use_free;
  logic [IDX_W-1:0]      slot;
  logic [COUNT_BITS-1:0] bumped;

  always_comb begin
    active   = cmd_i.commit && (cap_q != '0);
    is_get   = (op_q == OP_GET);
    use_free = free_vld_q && !full_q;
    do_upd   = active && hit_q;
    do_ev    = active && !hit_q && !is_get && !use_free && vic_vld_q;
    do_ins   = active && !hit_q && !is_get && (use_free || vic_vld_q);
    slot     = hit_q ? hit_idx_q : (use_free ? free_idx_q : vic_idx_q);
    bumped   = (cnt_q[hit_idx_q] == COUNT_MAX) ? COUNT_MAX : cnt_q[hit_idx_q] + 1'b1;
  end

  // Entry payload writes
  always_ff @(posedge clk_i) begin
    if (do_upd) begin
      if (!is_get) val_q[slot] <= rval_q;
      cnt_q[slot]   <= bumped;
      stamp_q[slot] <= clock_q;
    end else if (do_ins) begin
      key_q[slot]   <= rkey_q;
      val_q[slot]   <= rval_q;
      cnt_q[slot]   <= COUNT_BITS'(1);
      stamp_q[slot] <= clock_q;
    end
  end

  // Valid bits, occupancy and access clock
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) valid_q[i] <= 1'b0;
      occ_q   <= '0;
      clock_q <= '0;
    end else begin
      if (do_ins) valid_q[slot] <= 1'b1;
      if (do_ins && use_free) occ_q <= occ_q + 1'b1;
      if (do_upd || do_ins) clock_q <= clock_q + 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      found_q <= do_upd;
      rd_q    <= (do_upd && is_get) ? val_q[hit_idx_q] : '0;
      ev_q    <= do_ev;
      evkey_q <= do_ev ? KEY_W'(key_q[vic_idx_q]) : '0;
    end
  end

  assign rsp_found_o       = found_q;
  assign rsp_read_value_o  = rd_q;
  assign rsp_evicted_o     = ev_q;
  assign rsp_evicted_key_o = evkey_q;

  // Occupancy counter tracks the valid bits
  logic [OCC_W-1:0] vcount;
  always_comb begin
    vcount = '0;
    for (int i = 0; i < ENTRIES; i++) vcount = vcount + OCC_W'(valid_q[i]);
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q == vcount)
    else $error("occupancy out of step with valid bits");

  // An eviction always replaces a valid entry in place
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_ev |-> valid_q[vic_idx_q] && (occ_q != '0))
    else $error("eviction of an empty slot");

  // Access clock moves only on a commit step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.commit |=> (clock_q == $past(clock_q)))
    else $error("access clock moved outside commit");

endmodule

### src/lfu_cache_directory.sv
// LFU cache directory: each request steps through accept, search and commit; one request in flight.
// Search is a parallel key compare plus a min tree over (count, stamp) of all entries.
// Result is registered and appears the cycle after commit; a new request is taken
// while that result waits; commit holds while an earlier result is still not accepted.
// Reset: entries invalid, access clock zero, capacity 16; entry payload is not cleared.
// Top level; depends on lfu_pkg, lfu_ctrl and lfu_datapath.
module lfu_cache_directory #(
  parameter int unsigned ENTRIES    = lfu_pkg::LFU_ENTRIES,
  parameter int unsigned KEY_BITS   = lfu_pkg::LFU_KEY_BITS,
  parameter int unsigned COUNT_BITS = lfu_pkg::LFU_COUNT_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration write: capacity
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [lfu_pkg::CAP_W-1:0]     cfg_data_i,
  // Request stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [lfu_pkg::S_DATA_W-1:0]  s_axis_tdata,   // [15:0] key, [47:16] value
  input  logic                          s_axis_tuser,   // [0] operation
  // Result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [lfu_pkg::M_DATA_W-1:0]  m_axis_tdata,   // [31:0] read_value, [47:32] evicted_key
  output logic [lfu_pkg::M_USER_W-1:0]  m_axis_tuser    // [0] found, [1] evicted
);
  import lfu_pkg::*;

  lfu_cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  lfu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid),
    .req_ready_o (s_axis_tready),
    .rsp_valid_o (m_axis_tvalid),
    .rsp_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  lfu_datapath #(
    .ENTRIES    (ENTRIES),
    .KEY_BITS   (KEY_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_data_i        (cfg_data_i),
    .req_op_i          (s_axis_tuser),
    .req_key_i         (s_axis_tdata[KEY_W-1:0]),
    .req_value_i       (s_axis_tdata[KEY_W +: VALUE_W]),
    .rsp_found_o       (m_axis_tuser[0]),
    .rsp_read_value_o  (m_axis_tdata[VALUE_W-1:0]),
    .rsp_evicted_o     (m_axis_tuser[1]),
    .rsp_evicted_key_o (m_axis_tdata[VALUE_W +: KEY_W])
  );

endmodule

### tb/sv/tb.sv
// Self-checking testbench for lfu_cache_directory: directed and random request streams
// checked against an in-bench LFU directory model. Depends on lfu_pkg and the RTL top.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lfu_pkg::*;

  localparam int unsigned ENTRIES      = LFU_ENTRIES;
  localparam int unsigned CYCLE_LIMIT  = 2_000_000;
  localparam int unsigned SETTLE_TICKS = 16;
  localparam int unsigned REPORT_MAX   = 10;
  localparam int unsigned POOL_SIZE    = 20;

  // One directory response
  typedef struct packed {
    logic               found;
    logic [VALUE_W-1:0] read_value;
    logic               evicted;
    logic [KEY_W-1:0]   evicted_key;
  } access_result_t;

  // DUT connections
  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_valid_i = 1'b0;
  logic                cfg_ready_o;
  logic [CAP_W-1:0]    cfg_data_i = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;  // [15:0] key, [47:16] value
  logic                s_axis_tuser = 1'b0;  // [0] operation
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;  // [31:0] read_value, [47:32] evicted_key
  logic [M_USER_W-1:0] m_axis_tuser;  // [0] found, [1] evicted

  // Directory model state
  logic               dir_valid [ENTRIES];
  logic [KEY_W-1:0]   dir_key   [ENTRIES];
  logic [VALUE_W-1:0] dir_value [ENTRIES];
  logic [15:0]        dir_count [ENTRIES];
  logic [STAMP_W-1:0] dir_stamp [ENTRIES];
  logic [STAMP_W-1:0] dir_clock;
  logic [CAP_W-1:0]   dir_capacity;

  access_result_t pending_results[$];
  access_result_t got_result;
  access_result_t want_result;

  int unsigned    mismatches = 0;
  int unsigned    cycle_count = 0;
  int unsigned    sink_hold = 0;
  int unsigned    sink_stall_len;
  bit             src_idling = 1'b1;
  bit             sink_idling = 1'b1;
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  lfu_cache_directory dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // 20 ns clock
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Run-away guard
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Idle length: mostly none or short, now and then long
  function automatic int unsigned idle_length();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void dir_reset();
    for (int i = 0; i < ENTRIES; i++) begin
      dir_valid[i] = 1'b0;
      dir_key[i]   = '0;
      dir_value[i] = '0;
      dir_count[i] = '0;
      dir_stamp[i] = '0;
    end
    dir_clock    = '0;
    dir_capacity = CAP_RESET;
  endfunction

  // LFU lookup/insert with (count, stamp, slot) victim order; updates the model
  function automatic access_result_t lfu_access(op_e op, logic [KEY_W-1:0] key,
                                                logic [VALUE_W-1:0] value);
    access_result_t res;
    int hit_slot;
    int free_slot;
    int victim_slot;
    int slot;
    int unsigned occupancy;
    int unsigned cap;
    res = '0;
    hit_slot = -1;
    free_slot = -1;
    victim_slot = -1;
    occupancy = 0;
    cap = (dir_capacity > ENTRIES) ? ENTRIES : dir_capacity;
    if (cap == 0) return res;
    for (int i = 0; i < ENTRIES; i++) begin
      if (dir_valid[i]) begin
        occupancy++;
        if (hit_slot < 0 && dir_key[i] == key) hit_slot = i;
        if (victim_slot < 0 || dir_count[i] < dir_count[victim_slot] ||
            (dir_count[i] == dir_count[victim_slot] &&
             dir_stamp[i] < dir_stamp[victim_slot]))
          victim_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    if (hit_slot >= 0) begin
      res.found = 1'b1;
      if (op == OP_GET) res.read_value = dir_value[hit_slot];
      else dir_value[hit_slot] = value;
      // count saturates at all ones
      if (dir_count[hit_slot] != '1) dir_count[hit_slot] = dir_count[hit_slot] + 1'b1;
      dir_stamp[hit_slot] = dir_clock;
      dir_clock = dir_clock + 1'b1;
    end else if (op == OP_PUT) begin
      slot = free_slot;
      if (occupancy >= cap || slot < 0) begin
        slot = victim_slot;
        res.evicted = 1'b1;
        res.evicted_key = dir_key[victim_slot];
      end
      if (slot >= 0) begin
        dir_valid[slot] = 1'b1;
        dir_key[slot]   = key;
        dir_value[slot] = value;
        dir_count[slot] = 16'd1;
        dir_stamp[slot] = dir_clock;
        dir_clock = dir_clock + 1'b1;
      end
    end
    return res;
  endfunction

  function automatic void note_mismatch(string msg);
    if (mismatches < REPORT_MAX) $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endfunction

  // Result checker: every accepted response against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_result.found       = m_axis_tuser[0];
      got_result.evicted     = m_axis_tuser[1];
      got_result.read_value  = m_axis_tdata[31:0];
      got_result.evicted_key = m_axis_tdata[47:32];
      if (pending_results.size() == 0) begin
        note_mismatch($sformatf("unexpected response found=%0b rd=%h ev=%0b evkey=%h",
                                got_result.found, got_result.read_value,
                                got_result.evicted, got_result.evicted_key));
      end else begin
        want_result = pending_results.pop_front();
        if (got_result.found !== want_result.found ||
            got_result.read_value !== want_result.read_value ||
            got_result.evicted !== want_result.evicted ||
            got_result.evicted_key !== want_result.evicted_key)
          note_mismatch($sformatf(
            "exp found=%0b rd=%h ev=%0b evkey=%h, got found=%0b rd=%h ev=%0b evkey=%h",
            want_result.found, want_result.read_value, want_result.evicted,
            want_result.evicted_key, got_result.found, got_result.read_value,
            got_result.evicted, got_result.evicted_key));
      end
    end
  end

  // Response backpressure
  always @(negedge clk_i) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
    end else begin
      sink_stall_len = sink_idling ? idle_length() : 0;
      m_axis_tready <= (sink_stall_len == 0);
      sink_hold <= (sink_stall_len == 0) ? 0 : sink_stall_len - 1;
    end
  end

  // Send one request; entered and left at a falling edge
  task automatic send_request(op_e op, logic [KEY_W-1:0] key, logic [VALUE_W-1:0] value);
    int unsigned gap;
    gap = src_idling ? idle_length() : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {value, key};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(lfu_access(op, key, value));
    @(negedge clk_i);
  endtask

  // Stop requesting and wait until all responses are back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SETTLE_TICKS) @(negedge clk_i);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] cap);
    drain_results();
    cfg_data_i  <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    dir_capacity = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Reset capacity: misses, inserts, hits, updates, key and value extremes
  task automatic test_basic_access();
    send_request(OP_GET, 16'h1234, 32'hDEAD_BEEF);
    send_request(OP_PUT, 16'h0000, 32'h8000_0000);
    send_request(OP_PUT, 16'hFFFF, 32'h7FFF_FFFF);
    send_request(OP_GET, 16'h0000, 32'h0);
    send_request(OP_GET, 16'hFFFF, 32'hFFFF_FFFF);
    send_request(OP_PUT, 16'h0000, 32'hFFFF_FFFF);
    send_request(OP_GET, 16'h0000, 32'h0);
    send_request(OP_GET, 16'h5555, 32'h0);
  endtask

  // Small capacity: victim by lowest count, then oldest stamp
  task automatic test_eviction_order();
    write_capacity(CAP_W'(3));
    send_request(OP_PUT, 16'd10, 32'd100);
    send_request(OP_PUT, 16'd20, 32'd200);
    send_request(OP_PUT, 16'd30, 32'd300);
    send_request(OP_PUT, 16'd40, 32'd400);
    send_request(OP_GET, 16'd20, 32'd0);
    send_request(OP_PUT, 16'd50, 32'd500);
    send_request(OP_GET, 16'd10, 32'd0);
    send_request(OP_GET, 16'd40, 32'd0);
  endtask

  // Zero capacity disables everything; state must survive
  task automatic test_zero_capacity();
    write_capacity(CAP_W'(0));
    send_request(OP_PUT, 16'd60, 32'd600);
    send_request(OP_GET, 16'd20, 32'd0);
    send_request(OP_PUT, 16'd20, 32'd1);
    write_capacity(CAP_W'(31));
    send_request(OP_GET, 16'd20, 32'd0);
  endtask

  // Frequency order: a heavily used entry must never become the victim
  task automatic test_frequency_order();
    src_idling  = 1'b0;
    sink_idling = 1'b0;
    write_capacity(CAP_W'(2));
    send_request(OP_PUT, 16'hA000, 32'h1111_1111);
    for (int i = 0; i < 6; i++) send_request(OP_GET, 16'hA000, 32'd0);
    send_request(OP_PUT, 16'hB000, 32'h2222_2222);
    repeat (3) send_request(OP_GET, 16'hB000, 32'd0);
    send_request(OP_PUT, 16'hC000, 32'h3333_3333);
    send_request(OP_PUT, 16'hD000, 32'h4444_4444);
    send_request(OP_GET, 16'hA000, 32'd0);
    src_idling  = 1'b1;
    sink_idling = 1'b1;
  endtask

  // One random phase over a small key pool so hits and evictions are common
  task automatic random_phase(logic [CAP_W-1:0] cap, int unsigned count, bit idling);
    logic [KEY_W-1:0]   key;
    logic [VALUE_W-1:0] value;
    op_e                op;
    write_capacity(cap);
    src_idling  = idling;
    sink_idling = idling;
    for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = KEY_W'($urandom());
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < count; n++) begin
      key = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : KEY_W'($urandom());
      case ($urandom_range(0, 9))
        0:       value = 32'h8000_0000;
        1:       value = 32'h7FFF_FFFF;
        2:       value = 32'hFFFF_FFFF;
        default: value = $urandom();
      endcase
      op = ($urandom_range(0, 1) == 1) ? OP_PUT : OP_GET;
      send_request(op, key, value);
    end
    src_idling  = 1'b1;
    sink_idling = 1'b1;
  endtask

  // Several capacities in turn, including shrink below occupancy and values above 16
  task automatic test_random_traffic();
    random_phase(CAP_W'(16), 120, 1'b1);
    random_phase(CAP_W'(1), 100, 1'b1);
    random_phase(CAP_W'(31), 120, 1'b0);
    random_phase(CAP_W'(4), 100, 1'b1);
    random_phase(CAP_W'(0), 20, 1'b1);
    random_phase(CAP_W'(2), 100, 1'b1);
    random_phase(CAP_W'(17), 120, 1'b1);
    random_phase(CAP_W'(8), 100, 1'b0);
    random_phase(CAP_W'($urandom_range(1, 15)), 120, 1'b1);
  endtask

  initial begin
    int unsigned wait_ticks;
    dir_reset();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_basic_access();
    test_eviction_order();
    test_zero_capacity();
    test_frequency_order();
    test_random_traffic();

    // Final drain with a bound, then settle
    s_axis_tvalid <= 1'b0;
    wait_ticks = 0;
    while (pending_results.size() != 0 && wait_ticks < 20000) begin
      @(posedge clk_i);
      wait_ticks++;
    end
    repeat (SETTLE_TICKS) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      $display("%0d responses never arrived", pending_results.size());
      mismatches += pending_results.size();
    end
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
